// ----- hw/rtl/trfe_pkg.sv -----
package trfe_pkg;

   // default sizes
   localparam int DEF_MAX_FRAMES       = 16;
   localparam int DEF_REGS_PER_FRAME   = 64;
   localparam int DEF_LOCALS_PER_FRAME = 64;
   localparam int MAX_FUNCTIONS        = 256;

   // opcodes
   localparam logic [4:0] OP_NOP         = 5'd0;
   localparam logic [4:0] OP_CONST_I64   = 5'd1;
   localparam logic [4:0] OP_CONST_BOOL  = 5'd2;
   localparam logic [4:0] OP_PRINT       = 5'd3;
   localparam logic [4:0] OP_RET         = 5'd4;
   localparam logic [4:0] OP_RET_VOID    = 5'd5;
   localparam logic [4:0] OP_LOAD_LOCAL  = 5'd6;
   localparam logic [4:0] OP_STORE_LOCAL = 5'd7;
   localparam logic [4:0] OP_ADD         = 5'd8;
   localparam logic [4:0] OP_SUB         = 5'd9;
   localparam logic [4:0] OP_MUL         = 5'd10;
   localparam logic [4:0] OP_DIV         = 5'd11;
   localparam logic [4:0] OP_MOD         = 5'd12;
   localparam logic [4:0] OP_EQ          = 5'd13;
   localparam logic [4:0] OP_NE          = 5'd14;
   localparam logic [4:0] OP_LT          = 5'd15;
   localparam logic [4:0] OP_LE          = 5'd16;
   localparam logic [4:0] OP_GT          = 5'd17;
   localparam logic [4:0] OP_GE          = 5'd18;
   localparam logic [4:0] OP_UNIMP_LO    = 5'd19;
   localparam logic [4:0] OP_UNIMP_HI    = 5'd21;
   localparam logic [4:0] OP_CALL        = 5'd22;
   localparam logic [4:0] OP_START       = 5'd23;

   // status codes
   localparam logic [3:0] ST_OK          = 4'd0;
   localparam logic [3:0] ST_RETURNED    = 4'd1;
   localparam logic [3:0] ST_NOT_LOADED  = 4'd2;
   localparam logic [3:0] ST_TYPE        = 4'd3;
   localparam logic [3:0] ST_DIV_ZERO    = 4'd4;
   localparam logic [3:0] ST_MOD_ZERO    = 4'd5;
   localparam logic [3:0] ST_UNIMP       = 4'd6;
   localparam logic [3:0] ST_OVERFLOW    = 4'd7;
   localparam logic [3:0] ST_UNKNOWN     = 4'd8;

   // value tags
   localparam logic [1:0] TAG_VOID = 2'd0;
   localparam logic [1:0] TAG_I64  = 2'd1;
   localparam logic [1:0] TAG_BOOL = 2'd2;

   // multiply / divide unit operations
   localparam logic [1:0] MD_MUL = 2'd0;
   localparam logic [1:0] MD_DIV = 2'd1;
   localparam logic [1:0] MD_REM = 2'd2;

   typedef struct packed {
      logic [1:0]  tag;
      logic [63:0] bits;
   } tval_type;

   typedef struct packed {
      logic       start;
      logic [1:0] kind;
   } md_cmd_type;

   localparam tval_type VOID_VAL = '{tag: TAG_VOID, bits: 64'd0};

endpackage

// ----- hw/rtl/trfe_muldiv.sv -----
module trfe_muldiv
   import trfe_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  md_cmd_type  md_cmd,
   input  logic [63:0] md_lhs,
   input  logic [63:0] md_rhs,
   output logic        md_done,
   output logic [63:0] md_result
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [1:0]  kind_ff, kind_in;
   logic        neg_q_ff, neg_q_in;
   logic        neg_r_ff, neg_r_in;
   logic [63:0] dvd_ff, dvd_in;
   logic [63:0] dvs_ff, dvs_in;
   logic [63:0] acc_ff, acc_in;
   logic [64:0] rem_shift;
   logic [64:0] diff;

   // one bit per cycle: shift-add multiply or restoring divide
   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      kind_in  = kind_ff;
      neg_q_in = neg_q_ff;
      neg_r_in = neg_r_ff;
      dvd_in   = dvd_ff;
      dvs_in   = dvs_ff;
      acc_in   = acc_ff;
      rem_shift = {acc_ff, dvd_ff[63]};
      diff      = rem_shift - {1'b0, dvs_ff};
      if (md_cmd.start) begin
         busy_in  = 1'b1;
         cnt_in   = 6'd0;
         kind_in  = md_cmd.kind;
         acc_in   = 64'd0;
         neg_q_in = md_lhs[63] ^ md_rhs[63];
         neg_r_in = md_lhs[63];
         if (md_cmd.kind == MD_MUL) begin
            dvd_in = md_lhs;
            dvs_in = md_rhs;
         end else begin
            dvd_in = md_lhs[63] ? (~md_lhs + 64'd1) : md_lhs;
            dvs_in = md_rhs[63] ? (~md_rhs + 64'd1) : md_rhs;
         end
      end else if (busy_ff) begin
         if (kind_ff == MD_MUL) begin
            if (dvd_ff[0]) begin
               acc_in = acc_ff + dvs_ff;
            end
            dvd_in = {1'b0, dvd_ff[63:1]};
            dvs_in = {dvs_ff[62:0], 1'b0};
         end else begin
            if (!diff[64]) begin
               acc_in = diff[63:0];
               dvd_in = {dvd_ff[62:0], 1'b1};
            end else begin
               acc_in = rem_shift[63:0];
               dvd_in = {dvd_ff[62:0], 1'b0};
            end
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff   <= cnt_in;
      kind_ff  <= kind_in;
      neg_q_ff <= neg_q_in;
      neg_r_ff <= neg_r_in;
      dvd_ff   <= dvd_in;
      dvs_ff   <= dvs_in;
      acc_ff   <= acc_in;
   end

   // sign fixup of the magnitudes
   always_comb begin
      case (kind_ff)
         MD_MUL:  md_result = acc_ff;
         MD_DIV:  md_result = neg_q_ff ? (~dvd_ff + 64'd1) : dvd_ff;
         MD_REM:  md_result = neg_r_ff ? (~acc_ff + 64'd1) : acc_ff;
         default: md_result = acc_ff;
      endcase
   end

   assign md_done = done_ff;

endmodule

// ----- hw/rtl/trfe_store.sv -----
module trfe_store
   import trfe_pkg::*;
#(
   parameter int REG_AW = 10,
   parameter int LOC_AW = 10
) (
   input  logic              clock,
   input  logic [REG_AW-1:0] reg_rd0_addr,
   input  logic [REG_AW-1:0] reg_rd1_addr,
   output tval_type          reg_rd0_data,
   output tval_type          reg_rd1_data,
   input  logic              reg_we,
   input  logic [REG_AW-1:0] reg_wr_addr,
   input  tval_type          reg_wr_data,
   input  logic [LOC_AW-1:0] loc_rd_addr,
   output tval_type          loc_rd_data,
   input  logic              loc_we,
   input  logic [LOC_AW-1:0] loc_wr_addr,
   input  tval_type          loc_wr_data
);

   tval_type reg_mem [2**REG_AW];
   tval_type loc_mem [2**LOC_AW];

   // register file: two read ports, one write port
   always_ff @(posedge clock) begin
      if (reg_we) begin
         reg_mem[reg_wr_addr] <= reg_wr_data;
      end
      reg_rd0_data <= reg_mem[reg_rd0_addr];
      reg_rd1_data <= reg_mem[reg_rd1_addr];
   end

   // locals: one read port, one write port
   always_ff @(posedge clock) begin
      if (loc_we) begin
         loc_mem[loc_wr_addr] <= loc_wr_data;
      end
      loc_rd_data <= loc_mem[loc_rd_addr];
   end

endmodule

// ----- hw/rtl/typed_register_frame_executor.sv -----
// channel   | direction | handshake             | payload
// req_      | in        | req_valid / req_stall | one instruction
// rsp_      | out       | rsp_valid / rsp_stall | status, value and type, print flag, depth, callee
//
// each instruction passes through capture, read, execute and result stages;
// mul, div and mod wait in the bit-serial unit, call runs the frame clear and argument
// copy through the memory ports, and start clears frame zero in place of execute.
// reset is synchronous and active high; the memories need no clearing pass.
// a stalled response only holds the next instruction in its result stage.
module typed_register_frame_executor
   import trfe_pkg::*;
#(
   parameter int MAX_FRAMES       = DEF_MAX_FRAMES,
   parameter int REGS_PER_FRAME   = DEF_REGS_PER_FRAME,
   parameter int LOCALS_PER_FRAME = DEF_LOCALS_PER_FRAME
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [4:0]  req_operation,
   input  logic [5:0]  req_dest_index,
   input  logic [5:0]  req_src1_index,
   input  logic [5:0]  req_src2_index,
   input  logic signed [63:0] req_immediate,
   input  logic [7:0]  req_callee_function,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_status,
   output logic signed [63:0] rsp_value,
   output logic [1:0]  rsp_value_type,
   output logic        rsp_print_valid,
   output logic [4:0]  rsp_frame_depth,
   output logic [7:0]  rsp_callee_index
);

   localparam int FW   = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
   localparam int DW   = $clog2(MAX_FRAMES + 1);
   localparam int RW   = (REGS_PER_FRAME > 1) ? $clog2(REGS_PER_FRAME) : 1;
   localparam int LW   = (LOCALS_PER_FRAME > 1) ? $clog2(LOCALS_PER_FRAME) : 1;
   localparam int MAXE = (REGS_PER_FRAME > LOCALS_PER_FRAME) ?
                         REGS_PER_FRAME : LOCALS_PER_FRAME;
   localparam int CW   = (MAXE > 1) ? $clog2(MAXE) : 1;
   localparam int SW   = $clog2(64 + MAXE);
   localparam int NW   = $clog2(REGS_PER_FRAME + 1);

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_READ    = 4'd1;
   localparam logic [3:0] S_EXEC    = 4'd2;
   localparam logic [3:0] S_MULDIV  = 4'd3;
   localparam logic [3:0] S_CALL_RD = 4'd4;
   localparam logic [3:0] S_CALL_WR = 4'd5;
   localparam logic [3:0] S_CLEAR   = 4'd6;
   localparam logic [3:0] S_FINISH  = 4'd7;

   function automatic logic [255:0][7:0] build_callee_tab();
      logic [255:0][7:0] t;
      for (int i = 0; i < 256; i++) begin
         t[i] = 8'(i % MAX_FUNCTIONS);
      end
      return t;
   endfunction

   localparam logic [255:0][7:0] CALLEE_TAB = build_callee_tab();

   logic [3:0]    state_ff, state_in;
   logic [4:0]    op_ff;
   logic [5:0]    a_ff, b_ff, c_ff;
   logic [63:0]   imm_ff;
   logic [7:0]    callee_ff;
   logic [DW-1:0] frames_ff, frames_in;
   logic          running_ff, running_in;
   logic          finished_ff, finished_in;
   tval_type      final_ff, final_in;
   logic [5:0]    ret_slot_ff [MAX_FRAMES];
   logic          slot_we, slot_clr;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [NW-1:0] n_ff, n_in;
   logic [3:0]    pst_ff, pst_in;
   tval_type      pshow_ff, pshow_in;
   logic          pprint_ff, pprint_in;
   logic [7:0]    pcallee_ff, pcallee_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_load;
   logic [3:0]    rsp_status_ff;
   tval_type      rsp_show_ff;
   logic          rsp_print_ff;
   logic [4:0]    rsp_depth_ff;
   logic [7:0]    rsp_callee_ff;

   logic [FW-1:0]    f_cur, f_next, f_prev;
   logic [SW-1:0]    src_idx;
   logic             a_reg_ok, b_reg_ok, c_reg_ok, b_loc_ok, a_loc_ok, src0_ok;
   logic             ret_op;
   logic [5:0]       slot_cur;
   tval_type         v0, v1, lv;
   logic             cmp_res;

   logic [FW+RW-1:0] reg_rd0_addr, reg_rd1_addr, reg_wr_addr;
   logic [FW+LW-1:0] loc_rd_addr, loc_wr_addr;
   tval_type         reg_rd0_data, reg_rd1_data, loc_rd_data;
   tval_type         reg_wr_data, loc_wr_data;
   logic             reg_we, loc_we;

   md_cmd_type       md_cmd;
   logic             md_done;
   logic [63:0]      md_result;

   // frame and index decode
   always_comb begin
      f_cur    = FW'(frames_ff - DW'(1));
      f_next   = FW'(frames_ff);
      f_prev   = FW'(frames_ff - DW'(2));
      src_idx  = SW'(c_ff) + SW'(cnt_ff);
      a_reg_ok = 32'(a_ff) < REGS_PER_FRAME;
      b_reg_ok = 32'(b_ff) < REGS_PER_FRAME;
      c_reg_ok = 32'(c_ff) < REGS_PER_FRAME;
      a_loc_ok = 32'(a_ff) < LOCALS_PER_FRAME;
      b_loc_ok = 32'(b_ff) < LOCALS_PER_FRAME;
      ret_op   = (op_ff == OP_PRINT) || (op_ff == OP_RET);
      src0_ok  = ret_op ? a_reg_ok : b_reg_ok;
      slot_cur = ret_slot_ff[f_cur];
   end

   // read addresses
   always_comb begin
      if (state_ff == S_CALL_RD) begin
         reg_rd0_addr = {f_cur, RW'(src_idx)};
      end else if (ret_op) begin
         reg_rd0_addr = {f_cur, RW'(a_ff)};
      end else begin
         reg_rd0_addr = {f_cur, RW'(b_ff)};
      end
      reg_rd1_addr = {f_cur, RW'(c_ff)};
      loc_rd_addr  = {f_cur, LW'(b_ff)};
   end

   // operands, out-of-range indices read as void
   always_comb begin
      v0 = src0_ok ? reg_rd0_data : VOID_VAL;
      v1 = c_reg_ok ? reg_rd1_data : VOID_VAL;
      lv = b_loc_ok ? loc_rd_data : VOID_VAL;
      case (op_ff)
         OP_EQ:   cmp_res = v0.bits == v1.bits;
         OP_NE:   cmp_res = v0.bits != v1.bits;
         OP_LT:   cmp_res = $signed(v0.bits) < $signed(v1.bits);
         OP_LE:   cmp_res = $signed(v0.bits) <= $signed(v1.bits);
         OP_GT:   cmp_res = $signed(v0.bits) > $signed(v1.bits);
         default: cmp_res = $signed(v0.bits) >= $signed(v1.bits);
      endcase
   end

   // instruction sequencer
   always_comb begin
      state_in    = state_ff;
      frames_in   = frames_ff;
      running_in  = running_ff;
      finished_in = finished_ff;
      final_in    = final_ff;
      cnt_in      = cnt_ff;
      n_in        = n_ff;
      pst_in      = pst_ff;
      pshow_in    = pshow_ff;
      pprint_in   = pprint_ff;
      pcallee_in  = pcallee_ff;
      slot_we     = 1'b0;
      slot_clr    = 1'b0;
      reg_we      = 1'b0;
      reg_wr_addr = {f_cur, RW'(a_ff)};
      reg_wr_data = VOID_VAL;
      loc_we      = 1'b0;
      loc_wr_addr = {f_cur, LW'(a_ff)};
      loc_wr_data = v0;
      md_cmd      = '{start: 1'b0, kind: MD_MUL};
      rsp_load    = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_READ;
            end
         end
         S_READ: begin
            pst_in     = ST_OK;
            pshow_in   = VOID_VAL;
            pprint_in  = 1'b0;
            pcallee_in = 8'd0;
            cnt_in     = '0;
            state_in   = (op_ff == OP_START) ? S_CLEAR : S_EXEC;
         end
         S_EXEC: begin
            state_in = S_FINISH;
            if (!running_ff) begin
               pst_in = ST_NOT_LOADED;
            end else if (finished_ff) begin
               pst_in   = ST_RETURNED;
               pshow_in = final_ff;
            end else if (frames_ff == '0) begin
               pst_in = ST_NOT_LOADED;
            end else begin
               case (op_ff) inside
                  OP_NOP: begin
                  end
                  OP_CONST_I64: begin
                     reg_we      = a_reg_ok;
                     reg_wr_data = '{tag: TAG_I64, bits: imm_ff};
                  end
                  OP_CONST_BOOL: begin
                     reg_we      = a_reg_ok;
                     reg_wr_data = '{tag: TAG_BOOL, bits: {63'd0, imm_ff != 64'd0}};
                  end
                  OP_PRINT: begin
                     pshow_in  = v0;
                     pprint_in = 1'b1;
                  end
                  OP_RET, OP_RET_VOID: begin
                     frames_in = frames_ff - DW'(1);
                     if (f_cur == '0) begin
                        finished_in = 1'b1;
                        final_in    = (op_ff == OP_RET) ? v0 : VOID_VAL;
                        pst_in      = ST_RETURNED;
                        pshow_in    = (op_ff == OP_RET) ? v0 : VOID_VAL;
                     end else begin
                        reg_we      = 32'(slot_cur) < REGS_PER_FRAME;
                        reg_wr_addr = {f_prev, RW'(slot_cur)};
                        reg_wr_data = (op_ff == OP_RET) ? v0 : VOID_VAL;
                     end
                  end
                  OP_LOAD_LOCAL: begin
                     reg_we      = a_reg_ok;
                     reg_wr_data = lv;
                  end
                  OP_STORE_LOCAL: begin
                     loc_we = a_loc_ok;
                  end
                  [OP_ADD:OP_GE]: begin
                     if ((op_ff == OP_DIV || op_ff == OP_MOD) &&
                         v1.tag == TAG_I64 && v1.bits == 64'd0) begin
                        pst_in = (op_ff == OP_DIV) ? ST_DIV_ZERO : ST_MOD_ZERO;
                     end else if (v0.tag != TAG_I64 || v1.tag != TAG_I64) begin
                        pst_in = ST_TYPE;
                     end else if (op_ff >= OP_EQ) begin
                        reg_we      = a_reg_ok;
                        reg_wr_data = '{tag: TAG_BOOL, bits: {63'd0, cmp_res}};
                     end else if (op_ff == OP_ADD) begin
                        reg_we      = a_reg_ok;
                        reg_wr_data = '{tag: TAG_I64, bits: v0.bits + v1.bits};
                     end else if (op_ff == OP_SUB) begin
                        reg_we      = a_reg_ok;
                        reg_wr_data = '{tag: TAG_I64, bits: v0.bits - v1.bits};
                     end else begin
                        md_cmd.start = 1'b1;
                        md_cmd.kind  = (op_ff == OP_MUL) ? MD_MUL :
                                       (op_ff == OP_DIV) ? MD_DIV : MD_REM;
                        state_in     = S_MULDIV;
                     end
                  end
                  [OP_UNIMP_LO:OP_UNIMP_HI]: begin
                     pst_in = ST_UNIMP;
                  end
                  OP_CALL: begin
                     if (32'(frames_ff) >= MAX_FRAMES) begin
                        pst_in = ST_OVERFLOW;
                     end else begin
                        if (imm_ff[63]) begin
                           n_in = '0;
                        end else if (imm_ff > 64'(REGS_PER_FRAME)) begin
                           n_in = NW'(REGS_PER_FRAME);
                        end else begin
                           n_in = NW'(imm_ff);
                        end
                        state_in = S_CALL_RD;
                     end
                  end
                  default: begin
                     pst_in = ST_UNKNOWN;
                  end
               endcase
            end
         end
         S_MULDIV: begin
            if (md_done) begin
               reg_we      = a_reg_ok;
               reg_wr_data = '{tag: TAG_I64, bits: md_result};
               state_in    = S_FINISH;
            end
         end
         S_CALL_RD: begin
            state_in = S_CALL_WR;
         end
         S_CALL_WR: begin
            // clear the new frame, copying the arguments over its first registers
            reg_we      = 32'(cnt_ff) < REGS_PER_FRAME;
            reg_wr_addr = {f_next, RW'(cnt_ff)};
            reg_wr_data = (32'(cnt_ff) < 32'(n_ff) && 32'(src_idx) < REGS_PER_FRAME) ?
                          reg_rd0_data : VOID_VAL;
            loc_we      = 32'(cnt_ff) < LOCALS_PER_FRAME;
            loc_wr_addr = {f_next, LW'(cnt_ff)};
            loc_wr_data = VOID_VAL;
            cnt_in      = cnt_ff + CW'(1);
            if (cnt_ff == CW'(MAXE - 1)) begin
               slot_we    = 1'b1;
               frames_in  = frames_ff + DW'(1);
               pcallee_in = callee_ff;
               state_in   = S_FINISH;
            end else begin
               state_in = S_CALL_RD;
            end
         end
         S_CLEAR: begin
            reg_we      = 32'(cnt_ff) < REGS_PER_FRAME;
            reg_wr_addr = {FW'(0), RW'(cnt_ff)};
            loc_we      = 32'(cnt_ff) < LOCALS_PER_FRAME;
            loc_wr_addr = {FW'(0), LW'(cnt_ff)};
            loc_wr_data = VOID_VAL;
            cnt_in      = cnt_ff + CW'(1);
            if (cnt_ff == CW'(MAXE - 1)) begin
               slot_clr    = 1'b1;
               running_in  = 1'b1;
               finished_in = 1'b0;
               final_in    = VOID_VAL;
               frames_in   = DW'(1);
               pcallee_in  = callee_ff;
               state_in    = S_FINISH;
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      rsp_valid_in = (rsp_valid_ff && rsp_stall) || rsp_load;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         frames_ff    <= '0;
         running_ff   <= 1'b0;
         finished_ff  <= 1'b0;
         final_ff     <= VOID_VAL;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < MAX_FRAMES; i++) begin
            ret_slot_ff[i] <= 6'd0;
         end
      end else begin
         state_ff     <= state_in;
         frames_ff    <= frames_in;
         running_ff   <= running_in;
         finished_ff  <= finished_in;
         final_ff     <= final_in;
         rsp_valid_ff <= rsp_valid_in;
         if (slot_clr) begin
            for (int i = 0; i < MAX_FRAMES; i++) begin
               ret_slot_ff[i] <= 6'd0;
            end
         end else if (slot_we) begin
            ret_slot_ff[f_next] <= a_ff;
         end
      end
   end

   // transaction capture and working registers
   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && req_valid) begin
         op_ff     <= req_operation;
         a_ff      <= req_dest_index;
         b_ff      <= req_src1_index;
         c_ff      <= req_src2_index;
         imm_ff    <= req_immediate;
         callee_ff <= CALLEE_TAB[req_callee_function];
      end
      cnt_ff     <= cnt_in;
      n_ff       <= n_in;
      pst_ff     <= pst_in;
      pshow_ff   <= pshow_in;
      pprint_ff  <= pprint_in;
      pcallee_ff <= pcallee_in;
      if (rsp_load) begin
         rsp_status_ff <= pst_ff;
         rsp_show_ff   <= pshow_ff;
         rsp_print_ff  <= pprint_ff;
         rsp_depth_ff  <= 5'(frames_ff);
         rsp_callee_ff <= pcallee_ff;
      end
   end

   trfe_store #(
      .REG_AW(FW + RW),
      .LOC_AW(FW + LW)
   ) u_store (
      .clock        (clock),
      .reg_rd0_addr (reg_rd0_addr),
      .reg_rd1_addr (reg_rd1_addr),
      .reg_rd0_data (reg_rd0_data),
      .reg_rd1_data (reg_rd1_data),
      .reg_we       (reg_we),
      .reg_wr_addr  (reg_wr_addr),
      .reg_wr_data  (reg_wr_data),
      .loc_rd_addr  (loc_rd_addr),
      .loc_rd_data  (loc_rd_data),
      .loc_we       (loc_we),
      .loc_wr_addr  (loc_wr_addr),
      .loc_wr_data  (loc_wr_data)
   );

   trfe_muldiv u_muldiv (
      .clock     (clock),
      .reset     (reset),
      .md_cmd    (md_cmd),
      .md_lhs    (v0.bits),
      .md_rhs    (v1.bits),
      .md_done   (md_done),
      .md_result (md_result)
   );

   // ports
   assign req_stall        = (state_ff != S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_value        = (rsp_show_ff.tag == TAG_VOID) ? 64'sd0 : rsp_show_ff.bits;
   assign rsp_value_type   = rsp_show_ff.tag;
   assign rsp_print_valid  = rsp_print_ff;
   assign rsp_frame_depth  = rsp_depth_ff;
   assign rsp_callee_index = rsp_callee_ff;

   // checks
   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      32'(frames_ff) <= MAX_FRAMES)
      else $error("frame depth beyond limit");

   a_finished_running: assert property (@(posedge clock) disable iff (reset)
      finished_ff |-> running_ff)
      else $error("finished without running");

   a_md_done_state: assert property (@(posedge clock) disable iff (reset)
      md_done |-> state_ff == S_MULDIV)
      else $error("multiply/divide result outside its wait state");

   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE || state_ff == S_FINISH) |-> !reg_we && !loc_we)
      else $error("memory write outside an active instruction");

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps

module tb;
   import trfe_pkg::*;

   typedef struct {
      logic [4:0]  op;
      logic [5:0]  a;
      logic [5:0]  b;
      logic [5:0]  c;
      logic [63:0] imm;
      logic [7:0]  callee;
   } instr_type;

   typedef struct {
      logic [3:0]  status;
      logic [63:0] value;
      logic [1:0]  vtype;
      logic        printed;
      logic [4:0]  depth;
      logic [7:0]  callee;
   } outcome_type;

   typedef struct {
      instr_type   ins;
      bit          typed;
      outcome_type res;
   } row_type;

   localparam int NFRAMES = DEF_MAX_FRAMES;
   localparam int NREGS   = DEF_REGS_PER_FRAME;
   localparam int NLOCALS = DEF_LOCALS_PER_FRAME;
   localparam int RANDOM_ITEMS = 1800;
   localparam int CYCLE_LIMIT  = 3000000;
   localparam logic [63:0] MIN_I64 = 64'h8000_0000_0000_0000;
   localparam logic [63:0] MAX_I64 = 64'h7fff_ffff_ffff_ffff;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [4:0]  req_operation;
   logic [5:0]  req_dest_index;
   logic [5:0]  req_src1_index;
   logic [5:0]  req_src2_index;
   logic signed [63:0] req_immediate;
   logic [7:0]  req_callee_function;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [3:0]  rsp_status;
   logic signed [63:0] rsp_value;
   logic [1:0]  rsp_value_type;
   logic        rsp_print_valid;
   logic [4:0]  rsp_frame_depth;
   logic [7:0]  rsp_callee_index;

   // executor state as the predictor sees it
   tval_type    frame_regs [NFRAMES][NREGS];
   tval_type    frame_locals [NFRAMES][NLOCALS];
   logic [5:0]  ret_dest [NFRAMES];
   int          depth;
   bit          running;
   bit          finished;
   tval_type    final_val;

   outcome_type pending_outcomes [$];
   int          errors;
   int          cycles;
   bit          send_burst_mode;

   typed_register_frame_executor u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_operation(req_operation), .req_dest_index(req_dest_index),
      .req_src1_index(req_src1_index), .req_src2_index(req_src2_index),
      .req_immediate(req_immediate), .req_callee_function(req_callee_function),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_status(rsp_status), .rsp_value(rsp_value),
      .rsp_value_type(rsp_value_type), .rsp_print_valid(rsp_print_valid),
      .rsp_frame_depth(rsp_frame_depth), .rsp_callee_index(rsp_callee_index)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic void clear_frame(int f);
      for (int i = 0; i < NREGS; i++) frame_regs[f][i] = VOID_VAL;
      for (int i = 0; i < NLOCALS; i++) frame_locals[f][i] = VOID_VAL;
      ret_dest[f] = '0;
   endfunction

   function automatic void clear_machine();
      for (int f = 0; f < NFRAMES; f++) clear_frame(f);
      depth = 0;
      running = 0;
      finished = 0;
      final_val = VOID_VAL;
   endfunction

   function automatic tval_type read_reg(int f, int idx);
      if (idx >= NREGS) return VOID_VAL;
      return frame_regs[f][idx];
   endfunction

   function automatic tval_type make_val(logic [1:0] tag, logic [63:0] bits);
      tval_type v;
      v.tag = tag;
      v.bits = bits;
      return v;
   endfunction

   // signed divide on magnitudes so that min / -1 wraps
   function automatic logic [63:0] signed_divide(logic [63:0] x, logic [63:0] y, bit rem);
      logic [63:0] mx;
      logic [63:0] my;
      logic [63:0] q;
      mx = x[63] ? -x : x;
      my = y[63] ? -y : y;
      if (rem) begin
         q = mx % my;
         return x[63] ? -q : q;
      end
      q = mx / my;
      return (x[63] != y[63]) ? -q : q;
   endfunction

   // execute one instruction on the predicted state
   function automatic outcome_type execute_instr(instr_type ins);
      outcome_type o;
      tval_type shown;
      tval_type l;
      tval_type r;
      logic [63:0] res;
      int f;
      int n;
      bit cond;
      o = '{default: '0};
      shown = VOID_VAL;
      if (ins.op == OP_START) begin
         clear_machine();
         running = 1;
         depth = 1;
         o.callee = ins.callee;
      end else if (!running) begin
         o.status = ST_NOT_LOADED;
      end else if (finished) begin
         o.status = ST_RETURNED;
         shown = final_val;
      end else if (depth == 0 || depth > NFRAMES) begin
         o.status = ST_NOT_LOADED;
      end else begin
         f = depth - 1;
         case (ins.op)
            OP_NOP: ;
            OP_CONST_I64: frame_regs[f][ins.a] = make_val(TAG_I64, ins.imm);
            OP_CONST_BOOL:
               frame_regs[f][ins.a] = make_val(TAG_BOOL, (ins.imm != 0) ? 64'd1 : 64'd0);
            OP_PRINT: begin
               shown = read_reg(f, ins.a);
               o.printed = 1'b1;
            end
            OP_RET, OP_RET_VOID: begin
               l = (ins.op == OP_RET) ? read_reg(f, ins.a) : VOID_VAL;
               depth = f;
               if (f == 0) begin
                  final_val = l;
                  finished = 1;
                  o.status = ST_RETURNED;
                  shown = l;
               end else begin
                  frame_regs[f-1][ret_dest[f]] = l;
               end
            end
            OP_LOAD_LOCAL: frame_regs[f][ins.a] = frame_locals[f][ins.b];
            OP_STORE_LOCAL: frame_locals[f][ins.a] = read_reg(f, ins.b);
            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD,
            OP_EQ, OP_NE, OP_LT, OP_LE, OP_GT, OP_GE: begin
               l = read_reg(f, ins.b);
               r = read_reg(f, ins.c);
               if ((ins.op == OP_DIV || ins.op == OP_MOD) && r.tag == TAG_I64 && r.bits == 0)
                  o.status = (ins.op == OP_DIV) ? ST_DIV_ZERO : ST_MOD_ZERO;
               else if (l.tag != TAG_I64 || r.tag != TAG_I64)
                  o.status = ST_TYPE;
               else if (ins.op >= OP_EQ) begin
                  case (ins.op)
                     OP_EQ: cond = $signed(l.bits) == $signed(r.bits);
                     OP_NE: cond = $signed(l.bits) != $signed(r.bits);
                     OP_LT: cond = $signed(l.bits) < $signed(r.bits);
                     OP_LE: cond = $signed(l.bits) <= $signed(r.bits);
                     OP_GT: cond = $signed(l.bits) > $signed(r.bits);
                     default: cond = $signed(l.bits) >= $signed(r.bits);
                  endcase
                  frame_regs[f][ins.a] = make_val(TAG_BOOL, {63'd0, cond});
               end else begin
                  case (ins.op)
                     OP_ADD: res = l.bits + r.bits;
                     OP_SUB: res = l.bits - r.bits;
                     OP_MUL: res = l.bits * r.bits;
                     default: res = signed_divide(l.bits, r.bits, ins.op == OP_MOD);
                  endcase
                  frame_regs[f][ins.a] = make_val(TAG_I64, res);
               end
            end
            OP_CALL: begin
               if (depth >= NFRAMES) o.status = ST_OVERFLOW;
               else begin
                  clear_frame(f + 1);
                  ret_dest[f+1] = ins.a;
                  if (ins.imm[63]) n = 0;
                  else n = (ins.imm > NREGS) ? NREGS : int'(ins.imm);
                  for (int i = 0; i < n; i++) frame_regs[f+1][i] = read_reg(f, ins.c + i);
                  depth = f + 2;
                  o.callee = ins.callee;
               end
            end
            default: begin
               if (ins.op >= OP_UNIMP_LO && ins.op <= OP_UNIMP_HI) o.status = ST_UNIMP;
               else o.status = ST_UNKNOWN;
            end
         endcase
      end
      o.value = (shown.tag == TAG_VOID) ? 64'd0 : shown.bits;
      o.vtype = shown.tag;
      o.depth = depth[4:0];
      return o;
   endfunction

   task automatic report(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycles);
      errors++;
   endtask

   // drive one transaction and hold it until accepted
   task automatic send_instr(instr_type ins, bit typed, outcome_type typed_res);
      outcome_type predicted;
      req_valid <= 1'b1;
      req_operation <= ins.op;
      req_dest_index <= ins.a;
      req_src1_index <= ins.b;
      req_src2_index <= ins.c;
      req_immediate <= ins.imm;
      req_callee_function <= ins.callee;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = execute_instr(ins);
      pending_outcomes.push_back(typed ? typed_res : predicted);
   endtask

   // bursty sender: sometimes drops valid between transactions
   task automatic sender_gap();
      int gap;
      if (send_burst_mode && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 6);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      if ($urandom_range(0, 19) == 0) send_burst_mode = !send_burst_mode;
   endtask

   function automatic instr_type mk_ins(logic [4:0] op, logic [5:0] a, logic [5:0] b,
                                        logic [5:0] c, logic [63:0] imm, logic [7:0] callee);
      instr_type i;
      i.op = op; i.a = a; i.b = b; i.c = c; i.imm = imm; i.callee = callee;
      return i;
   endfunction

   function automatic outcome_type mk_res(logic [3:0] st, logic [63:0] v, logic [1:0] t,
                                          logic p, logic [4:0] d, logic [7:0] ce);
      outcome_type o;
      o.status = st; o.value = v; o.vtype = t; o.printed = p; o.depth = d; o.callee = ce;
      return o;
   endfunction

   function automatic logic [5:0] pick_index();
      return ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, 7));
   endfunction

   function automatic logic [63:0] pick_imm();
      case ($urandom_range(0, 5))
         0: return MIN_I64;
         1: return MAX_I64;
         2: return {$urandom, $urandom};
         3: return -64'($urandom_range(0, 5));
         default: return 64'($urandom_range(0, 20));
      endcase
   endfunction

   // mostly well-formed programs with random content, plus some noise
   function automatic instr_type random_instr();
      instr_type i;
      int w;
      i = mk_ins(OP_NOP, pick_index(), pick_index(), pick_index(), pick_imm(), 8'($urandom));
      w = $urandom_range(0, 99);
      if ((!running || (finished && w < 70)) || w == 99) i.op = OP_START;
      else if (w < 25) i.op = OP_CONST_I64;
      else if (w < 30) i.op = OP_CONST_BOOL;
      else if (w < 55) i.op = 5'($urandom_range(OP_ADD, OP_GE));
      else if (w < 60) i.op = OP_PRINT;
      else if (w < 64) i.op = OP_LOAD_LOCAL;
      else if (w < 68) i.op = OP_STORE_LOCAL;
      else if (w < 80) begin
         i.op = OP_CALL;
         case ($urandom_range(0, 7))
            0: i.imm = -64'($urandom_range(1, 3));
            1: i.imm = 64'($urandom_range(60, 80));
            2: i.imm = {$urandom, $urandom};
            default: i.imm = 64'($urandom_range(0, 8));
         endcase
      end else if (w < 85) i.op = OP_RET;
      else if (w < 88) i.op = OP_RET_VOID;
      else if (w < 92) i.op = OP_NOP;
      else i.op = 5'($urandom_range(OP_UNIMP_LO, 31));
      return i;
   endfunction

   // receiver stall pattern: phases of none, light and heavy stalling
   int stall_phase;
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_phase <= 0;
      end else begin
         if ($urandom_range(0, 63) == 0) stall_phase <= $urandom_range(0, 2);
         case (stall_phase)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            default: rsp_stall <= ($urandom_range(0, 9) < 7);
         endcase
      end
   end

   // response checker
   always @(posedge clock) begin
      outcome_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_outcomes.size() == 0) begin
            $display("unexpected response transaction at cycle %0d", cycles);
            errors++;
         end else begin
            want = pending_outcomes.pop_front();
            if (rsp_status !== want.status)
               report("status", 64'(rsp_status), 64'(want.status));
            if (rsp_value !== want.value) report("value", rsp_value, want.value);
            if (rsp_value_type !== want.vtype)
               report("value_type", 64'(rsp_value_type), 64'(want.vtype));
            if (rsp_print_valid !== want.printed)
               report("print_valid", 64'(rsp_print_valid), 64'(want.printed));
            if (rsp_frame_depth !== want.depth)
               report("frame_depth", 64'(rsp_frame_depth), 64'(want.depth));
            if (rsp_callee_index !== want.callee)
               report("callee_index", 64'(rsp_callee_index), 64'(want.callee));
         end
      end
   end

   // timeout
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   row_type directed [$];
   outcome_type no_res;

   initial begin
      errors = 0;
      cycles = 0;
      send_burst_mode = 1;
      reset = 1'b1;
      req_valid = 1'b0;
      req_operation = OP_NOP;
      req_dest_index = '0;
      req_src1_index = '0;
      req_src2_index = '0;
      req_immediate = '0;
      req_callee_function = '0;
      no_res = '{default: '0};
      clear_machine();

      // directed table
      directed = '{
         '{mk_ins(OP_NOP, 6'd63, 6'd63, 6'd63, MAX_I64, 8'hff), 1,
           mk_res(ST_NOT_LOADED, 64'd0, TAG_VOID, 1'b0, 5'd0, 8'd0)},
         '{mk_ins(OP_START, 6'd0, 6'd0, 6'd0, 64'd0, 8'hff), 1,
           mk_res(ST_OK, 64'd0, TAG_VOID, 1'b0, 5'd1, 8'hff)},
         '{mk_ins(OP_CONST_I64, 6'd0, 6'd0, 6'd0, MIN_I64, 8'd0), 0, no_res},
         '{mk_ins(OP_CONST_I64, 6'd1, 6'd0, 6'd0, -64'd1, 8'd0), 0, no_res},
         '{mk_ins(OP_DIV, 6'd2, 6'd0, 6'd1, 64'd0, 8'd0), 0, no_res},
         '{mk_ins(OP_MOD, 6'd3, 6'd0, 6'd1, 64'd0, 8'd0), 0, no_res},
         '{mk_ins(OP_PRINT, 6'd2, 6'd0, 6'd0, 64'd0, 8'd0), 1,
           mk_res(ST_OK, MIN_I64, TAG_I64, 1'b1, 5'd1, 8'd0)},
         '{mk_ins(OP_CONST_I64, 6'd4, 6'd0, 6'd0, 64'd0, 8'd0), 0, no_res},
         '{mk_ins(OP_DIV, 6'd5, 6'd0, 6'd4, 64'd0, 8'd0), 1,
           mk_res(ST_DIV_ZERO, 64'd0, TAG_VOID, 1'b0, 5'd1, 8'd0)},
         '{mk_ins(OP_MOD, 6'd5, 6'd40, 6'd4, 64'd0, 8'd0), 1,
           mk_res(ST_MOD_ZERO, 64'd0, TAG_VOID, 1'b0, 5'd1, 8'd0)},
         '{mk_ins(OP_CONST_BOOL, 6'd6, 6'd0, 6'd0, 64'd5, 8'd0), 0, no_res},
         '{mk_ins(OP_ADD, 6'd7, 6'd6, 6'd0, 64'd0, 8'd0), 1,
           mk_res(ST_TYPE, 64'd0, TAG_VOID, 1'b0, 5'd1, 8'd0)},
         '{mk_ins(OP_CONST_I64, 6'd8, 6'd0, 6'd0, MAX_I64, 8'd0), 0, no_res},
         '{mk_ins(OP_ADD, 6'd9, 6'd8, 6'd8, 64'd0, 8'd0), 0, no_res},
         '{mk_ins(OP_SUB, 6'd9, 6'd0, 6'd8, 64'd0, 8'd0), 0, no_res},
         '{mk_ins(OP_MUL, 6'd9, 6'd8, 6'd0, 64'd0, 8'd0), 0, no_res},
         '{mk_ins(OP_EQ, 6'd10, 6'd0, 6'd0, 64'd0, 8'd0), 0, no_res},
         '{mk_ins(OP_NE, 6'd10, 6'd0, 6'd8, 64'd0, 8'd0), 0, no_res},
         '{mk_ins(OP_LT, 6'd11, 6'd0, 6'd8, 64'd0, 8'd0), 0, no_res},
         '{mk_ins(OP_LE, 6'd11, 6'd8, 6'd0, 64'd0, 8'd0), 0, no_res},
         '{mk_ins(OP_GT, 6'd12, 6'd8, 6'd0, 64'd0, 8'd0), 0, no_res},
         '{mk_ins(OP_GE, 6'd12, 6'd1, 6'd1, 64'd0, 8'd0), 0, no_res},
         '{mk_ins(OP_STORE_LOCAL, 6'd63, 6'd8, 6'd0, 64'd0, 8'd0), 0, no_res},
         '{mk_ins(OP_LOAD_LOCAL, 6'd13, 6'd63, 6'd0, 64'd0, 8'd0), 0, no_res},
         '{mk_ins(5'd20, 6'd0, 6'd0, 6'd0, 64'd0, 8'd0), 1,
           mk_res(ST_UNIMP, 64'd0, TAG_VOID, 1'b0, 5'd1, 8'd0)},
         '{mk_ins(5'd31, 6'd0, 6'd0, 6'd0, 64'd0, 8'd0), 1,
           mk_res(ST_UNKNOWN, 64'd0, TAG_VOID, 1'b0, 5'd1, 8'd0)},
         // argument copy running past the caller frame
         '{mk_ins(OP_CALL, 6'd14, 6'd0, 6'd62, 64'd3, 8'd0), 0, no_res},
         '{mk_ins(OP_RET, 6'd0, 6'd0, 6'd0, 64'd0, 8'd0), 0, no_res},
         '{mk_ins(OP_CALL, 6'd15, 6'd0, 6'd0, MAX_I64, 8'h5a), 0, no_res},
         '{mk_ins(OP_RET_VOID, 6'd0, 6'd0, 6'd0, 64'd0, 8'd0), 0, no_res},
         '{mk_ins(OP_RET, 6'd8, 6'd0, 6'd0, 64'd0, 8'd0), 1,
           mk_res(ST_RETURNED, MAX_I64, TAG_I64, 1'b0, 5'd0, 8'd0)},
         '{mk_ins(OP_NOP, 6'd0, 6'd0, 6'd0, 64'd0, 8'd0), 1,
           mk_res(ST_RETURNED, MAX_I64, TAG_I64, 1'b0, 5'd0, 8'd0)}
      };

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[k]) begin
         send_instr(directed[k].ins, directed[k].typed, directed[k].res);
         sender_gap();
      end
      for (int k = 0; k < RANDOM_ITEMS; k++) begin
         send_instr(random_instr(), 0, no_res);
         sender_gap();
      end
      req_valid <= 1'b0;

      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (errors == 0) $display("Test completed successfully");
      else $display("Test completed with failures");
      $finish;
   end

endmodule
